>>> rtl/c2p_pkg.sv
// Shared constants, the arctangent table and the pipeline depth function
// of the Cartesian-to-polar converter. No dependencies.
package c2p_pkg;

  // Default configuration
  localparam int DEF_COORD_WIDTH = 16;
  localparam int DEF_ITERATIONS  = 16;

  // Datapath formats
  localparam int DP_W     = 64;  // CORDIC x/y width
  localparam int DP_POINT = 60;  // coordinates are scaled to this bit position
  localparam int Z_W      = 32;  // binary angle accumulator, pi/2^31 units
  localparam int RADIUS_W = 16;
  localparam int ANGLE_W  = 16;

  // Stages ahead of the iterations: prep, squares, sum
  localparam int PREP_STAGES = 3;

  localparam logic [Z_W-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [Z_W-1:0] ROUND_HALF = 32'h0000_8000;

  // atan(2^-i) * 2^31 / pi, rounded to nearest
  localparam logic [Z_W-1:0] ATAN_LUT [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Iteration stages: one root bit and one micro-rotation per stage
  function automatic int c2p_steps(input int coord_w, input int iters);
    return (coord_w > iters) ? coord_w : iters;
  endfunction

  // Total register stages from input to output
  function automatic int c2p_depth(input int coord_w, input int iters);
    return PREP_STAGES + c2p_steps(coord_w, iters);
  endfunction

endpackage

>>> rtl/c2p_intf.sv
// Valid/ready channel interfaces of the Cartesian-to-polar converter.
// Depends on c2p_pkg for default widths.
interface c2p_in_if #(
  parameter int COORD_WIDTH = c2p_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if;
  import c2p_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [RADIUS_W-1:0]       radius;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output radius, output angle, input ready);
  modport sink   (input valid, input radius, input angle, output ready);
endinterface

>>> rtl/cartesian_to_polar_top.sv
// Cartesian-to-polar converter: pipelined integer square root beside a
// pipelined vectoring CORDIC. Depends on c2p_pkg and c2p_intf.
//
//   channel | dir | payload                         | beat when
//   --------+-----+---------------------------------+------------------
//   in_i    | in  | x_coord, y_coord (signed)       | valid && ready
//   out_o   | out | radius (unsigned), angle (bam)  | valid && ready
//
// Accepts one beat per cycle while in_i.ready is high. Beats pass the prep,
// squares and sum stages, then iteration stages of one root bit and one
// micro-rotation each. Reset clears only the stage valid bits.
// A stall on out_o holds the unbroken run of full stages at the output; empty
// stages keep filling, so in_i stays ready until every stage holds a beat.
module cartesian_to_polar_top #(
  parameter int COORD_WIDTH = c2p_pkg::DEF_COORD_WIDTH,
  parameter int ITERATIONS  = c2p_pkg::DEF_ITERATIONS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  c2p_in_if.sink         in_i,
  c2p_out_if.source      out_o
);
  import c2p_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int SW    = 2 * COORD_WIDTH;
  localparam int SHL   = DP_POINT - COORD_WIDTH;
  localparam int DEPTH = c2p_depth(COORD_WIDTH, ITERATIONS);

  typedef struct packed {
    logic                   zero;
    logic [W-1:0]           ax;
    logic [W-1:0]           ay;
    logic [SW-1:0]          sqx;
    logic [SW-1:0]          sqy;
    logic [SW-1:0]          rem;
    logic [SW-1:0]          root;
    logic signed [DP_W-1:0] x;
    logic signed [DP_W-1:0] y;
    logic [Z_W-1:0]         z;
  } stage_t;

  stage_t             st_d [DEPTH];
  stage_t             st_q [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [DEPTH:0]     en;
  logic [Z_W-1:0]     z_rnd;

  // A stage advances when it is empty or its successor advances
  assign en[DEPTH] = out_o.ready;
  assign in_i.ready = en[0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_stage
    assign en[g] = !vld_q[g] || en[g+1];

    if (g == 0) begin : g_prep
      logic signed [DP_W-1:0] xe;
      logic signed [DP_W-1:0] ye;
      logic                   neg;

      // Scale, fold into the right half plane, take magnitudes
      always_comb begin
        xe  = DP_W'(in_i.x_coord) <<< SHL;
        ye  = DP_W'(in_i.y_coord) <<< SHL;
        neg = in_i.x_coord[W-1];
        st_d[0]      = '0;
        st_d[0].zero = (in_i.x_coord == '0) && (in_i.y_coord == '0);
        st_d[0].ax   = neg ? W'(-in_i.x_coord) : in_i.x_coord;
        st_d[0].ay   = in_i.y_coord[W-1] ? W'(-in_i.y_coord) : in_i.y_coord;
        if (neg) begin
          st_d[0].x = -xe;
          st_d[0].y = -ye;
          st_d[0].z = HALF_TURN;
        end else begin
          st_d[0].x = xe;
          st_d[0].y = ye;
          st_d[0].z = '0;
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[0] <= 1'b0;
        end else if (en[0]) begin
          vld_q[0] <= in_i.valid;
        end
      end
    end else begin : g_work
      if (g == 1) begin : g_square
        // Square both magnitudes
        always_comb begin
          st_d[1]     = st_q[0];
          st_d[1].sqx = SW'(st_q[0].ax) * SW'(st_q[0].ax);
          st_d[1].sqy = SW'(st_q[0].ay) * SW'(st_q[0].ay);
        end
      end else if (g == 2) begin : g_sum
        // Form the radicand
        always_comb begin
          st_d[2]      = st_q[1];
          st_d[2].rem  = st_q[1].sqx + st_q[1].sqy;
          st_d[2].root = '0;
        end
      end else begin : g_iter
        localparam int K      = g - PREP_STAGES;
        localparam int SQ_POS = (K < W) ? 2 * (W - 1 - K) : 0;
        localparam logic [SW-1:0] SQ_BIT = SW'(1) << SQ_POS;
        logic [SW-1:0] trial;

        // One root bit and one micro-rotation
        always_comb begin
          st_d[g] = st_q[g-1];
          trial   = st_q[g-1].root + SQ_BIT;
          if (K < W) begin
            if (st_q[g-1].rem >= trial) begin
              st_d[g].rem  = st_q[g-1].rem - trial;
              st_d[g].root = (st_q[g-1].root >> 1) + SQ_BIT;
            end else begin
              st_d[g].root = st_q[g-1].root >> 1;
            end
          end
          if (K < ITERATIONS) begin
            if (!st_q[g-1].y[DP_W-1]) begin
              st_d[g].x = st_q[g-1].x + (st_q[g-1].y >>> K);
              st_d[g].y = st_q[g-1].y - (st_q[g-1].x >>> K);
              st_d[g].z = st_q[g-1].z + ATAN_LUT[K];
            end else begin
              st_d[g].x = st_q[g-1].x - (st_q[g-1].y >>> K);
              st_d[g].y = st_q[g-1].y + (st_q[g-1].x >>> K);
              st_d[g].z = st_q[g-1].z - ATAN_LUT[K];
            end
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[g] <= 1'b0;
        end else if (en[g]) begin
          vld_q[g] <= vld_q[g-1];
        end
      end
    end

    // Advance the payload with its stage
    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  // Round the accumulator to the output angle; origin reads as zero
  assign z_rnd        = st_q[DEPTH-1].z + ROUND_HALF;
  assign out_o.valid  = vld_q[DEPTH-1];
  assign out_o.radius = st_q[DEPTH-1].root[RADIUS_W-1:0];
  assign out_o.angle  = st_q[DEPTH-1].zero ? '0 : z_rnd[Z_W-1 -: ANGLE_W];

endmodule

>>> rtl/c2p_checker.sv
// Port-level checks for the Cartesian-to-polar converter, bound to its top.
// Depends on c2p_pkg for the pipeline depth.
module c2p_checker #(
  parameter int COORD_WIDTH = c2p_pkg::DEF_COORD_WIDTH,
  parameter int ITERATIONS  = c2p_pkg::DEF_ITERATIONS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [c2p_pkg::RADIUS_W-1:0] radius_i,
  input logic [c2p_pkg::ANGLE_W-1:0]  angle_i
);
  import c2p_pkg::*;

  localparam int DEPTH = c2p_depth(COORD_WIDTH, ITERATIONS);
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic [CNT_W-1:0] cnt_d;
  logic [CNT_W-1:0] cnt_q;

  // Track beats in flight
  always_comb begin
    cnt_d = cnt_q + CNT_W'(in_valid_i && in_ready_i) - CNT_W'(out_valid_i && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(radius_i) && $stable(angle_i))
    else $error("stalled result changed");

  // Show nothing during reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // Never emit a result without a beat in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without a pending beat");

  // Never hold more beats than stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("more beats in flight than stages");

  // An empty output stage leaves the input open
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output stage");

endmodule

bind cartesian_to_polar_top c2p_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .ITERATIONS (ITERATIONS)
) u_c2p_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .radius_i   (out_o.radius),
  .angle_i    (out_o.angle)
);
